### hdl/ktsmp_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler package
// Shared constants, input kinds and register indexes of the sampler.
// ----------------------------------------------------------------------------
package ktsmp_pkg;

  localparam int MAX_KEYS_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  // One table entry: time in the low word, then x, y, z and w.
  localparam int ENTRY_W = 160;
  localparam int COMP_W  = 32;
  localparam int NCOMP   = 4;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_DATA_W = 7;

  // Input item kinds carried in tuser.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Register indexes.
  localparam logic CFG_LINEAR_MODE = 1'b0;
  localparam logic CFG_KEY_COUNT   = 1'b1;

endpackage

### hdl/keyframe_track_sampler_core.sv
// A load writes its table entry and leaves the core idle. A sample scans the keyframes in turn,
// reading and comparing each through the single table RAM port; in linear mode it then reads the
// next entry, runs the bit-serial division and multiplications, and rounds and saturates the result.
// The core takes one item at a time: input is accepted only in the idle state, after the previous
// sample has passed its result to the output register. Reset is asynchronous, active low; it
// clears control state and registers (linear_mode 1, key_count 0), not the keyframe table.
// ----------------------------------------------------------------------------
// Keyframe track sampler core
// Loads a keyframe table and samples it by step hold or linear interpolation.
// ----------------------------------------------------------------------------
module keyframe_track_sampler_core #(
  parameter int MAX_KEYS  = ktsmp_pkg::MAX_KEYS_DEF,
  parameter int FRAC_BITS = ktsmp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // tdata: key_index[5:0], key_time[37:6], comp_x[69:38], comp_y[101:70],
  //        comp_z[133:102], comp_w[165:134], query_time[197:166], zero pad.
  input  logic [ktsmp_pkg::IN_DATA_W-1:0]   s_tdata_i,
  // tuser: mode[0].
  input  logic                              s_tuser_i,
  // Result stream.
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96].
  output logic [ktsmp_pkg::OUT_DATA_W-1:0]  m_tdata_o,
  // tuser: error_flag[0].
  output logic                              m_tuser_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [ktsmp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int QW  = 32 + FRAC_BITS;      // quotient and multiplier width
  localparam int PW  = QW + 32;             // product width
  localparam int BW  = $clog2(QW);
  localparam int EW  = ktsmp_pkg::ENTRY_W;
  localparam int NC  = ktsmp_pkg::NCOMP;
  localparam logic [PW-1:0] LIM = PW'(1) << (FRAC_BITS + 33);
  localparam logic [PW-1:0] RND = (PW'(1) << FRAC_BITS) - PW'(1);
  localparam logic signed [35:0] SMAX = 36'sh07FFFFFFF;
  localparam logic signed [35:0] SMIN = -36'sh080000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_NX_RD, ST_NX_WAIT,
    ST_ENT_RD, ST_ENT_WAIT, ST_DIV, ST_MUL, ST_CALC, ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers. The port never stalls.
  logic         linear_q;
  logic [6:0]   key_count_q;

  // Output register.
  logic         ovalid_q;
  logic [31:0]  out_q [NC];
  logic         oerr_q;

  // Working registers of one sample transaction.
  logic [31:0]   qtime_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] idx_q;
  logic [AW-1:0] found_q;
  logic [EW-1:0] ent0_q;
  logic [EW-1:0] ent1_q;
  logic          err_q;
  logic          negk_q;
  logic [31:0]   mden_q;
  logic [31:0]   rem_q;
  logic [QW-1:0] dvd_q;
  logic [BW-1:0] bit_q;
  logic [31:0]   md_q   [NC];
  logic [PW-1:0] prod_q [NC];
  logic          neg_q  [NC];
  logic [31:0]   res_q  [NC];

  // Input fields.
  logic [5:0]  in_key_index;
  logic [31:0] in_query;
  logic        s_acc;
  assign in_key_index = s_tdata_i[5:0];
  assign in_query     = s_tdata_i[197:166];
  assign s_acc        = s_tvalid_i & s_tready_o;

  assign s_tready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Table RAM: one entry holds time and the four components.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_rdata;
  logic [AW-1:0] found_nx;
  assign found_nx = found_q + AW'(1);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(in_key_index);
    case (state_q)
      ST_IDLE: begin
        ram_we = s_acc && (s_tuser_i == ktsmp_pkg::MODE_LOAD) &&
                 (32'(in_key_index) < 32'(MAX_KEYS));
      end
      ST_SCAN_RD: ram_addr = idx_q;
      ST_NX_RD:   ram_addr = found_nx;
      ST_ENT_RD:  ram_addr = found_q;
      default:    ram_addr = idx_q;
    endcase
  end

  ktsmp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_KEYS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s_tdata_i[165:6]),
    .rdata_o (ram_rdata)
  );

  // Count in use, saturated to the table depth.
  logic [CW-1:0] count_sat;
  assign count_sat = (32'(key_count_q) > 32'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(key_count_q);

  // Scan compare.
  logic          scan_brk;
  logic          scan_take;
  logic          scan_last;
  logic [AW-1:0] found_n;
  logic          found_last;
  assign scan_brk   = qtime_q < ram_rdata[31:0];
  assign scan_take  = !scan_brk || (idx_q == '0);
  assign scan_last  = (CW'(idx_q) == cnt_q - CW'(1));
  assign found_n    = scan_brk ? found_q : idx_q;
  assign found_last = (CW'(found_n) == cnt_q - CW'(1));

  // Query offset into the segment and segment span, from the start entry and the fetched next entry.
  logic signed [32:0] num_s;
  logic signed [32:0] den_s;
  assign num_s = $signed({1'b0, qtime_q}) - $signed({1'b0, ent0_q[31:0]});
  assign den_s = $signed({1'b0, ram_rdata[31:0]}) - $signed({1'b0, ent0_q[31:0]});

  // Restoring division step.
  logic [32:0] trial;
  logic        qbit;
  assign trial = {rem_q, dvd_q[QW-1]};
  assign qbit  = trial >= {1'b0, mden_q};

  // Component differences for the multiply setup.
  logic signed [32:0] dif [NC];
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      dif[c] = $signed({ent1_q[32+32*c+31], ent1_q[32+32*c +: 32]}) -
               $signed({ent0_q[32+32*c+31], ent0_q[32+32*c +: 32]});
    end
  end

  // Final rounding toward minus infinity and saturation.
  logic [31:0] calc [NC];
  always_comb begin
    logic [PW-1:0]      shf;
    logic signed [35:0] sum;
    logic signed [35:0] a36;
    for (int c = 0; c < NC; c++) begin
      shf = neg_q[c] ? ((prod_q[c] + RND) >> FRAC_BITS) : (prod_q[c] >> FRAC_BITS);
      a36 = 36'($signed(ent0_q[32+32*c +: 32]));
      sum = neg_q[c] ? (a36 - $signed({2'b00, shf[33:0]}))
                     : (a36 + $signed({2'b00, shf[33:0]}));
      if (prod_q[c] > LIM) begin
        calc[c] = neg_q[c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (sum > SMAX) begin
        calc[c] = 32'h7FFF_FFFF;
      end else if (sum < SMIN) begin
        calc[c] = 32'h8000_0000;
      end else begin
        calc[c] = sum[31:0];
      end
    end
  end

  // Sequencer, configuration and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      linear_q    <= 1'b1;
      key_count_q <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ktsmp_pkg::CFG_LINEAR_MODE: linear_q    <= cfg_data_i[0];
          ktsmp_pkg::CFG_KEY_COUNT:   key_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      // The finishing state loads the next result itself.
      if (ovalid_q && m_tready_i && (state_q != ST_FIN)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc && (s_tuser_i == ktsmp_pkg::MODE_SAMPLE)) begin
            state_q <= (count_sat == '0) ? ST_ENT_RD : ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: state_q <= ST_SCAN_CMP;
        ST_SCAN_CMP: begin
          if (scan_brk || scan_last) begin
            state_q <= (!linear_q || found_last) ? ST_FIN : ST_NX_RD;
          end else begin
            state_q <= ST_SCAN_RD;
          end
        end
        ST_NX_RD: state_q <= ST_NX_WAIT;
        ST_NX_WAIT: state_q <= (den_s == '0) ? ST_FIN : ST_DIV;
        ST_ENT_RD: state_q <= ST_ENT_WAIT;
        ST_ENT_WAIT: state_q <= ST_FIN;
        ST_DIV: begin
          if (bit_q == '0) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (bit_q == '0) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: state_q <= ST_FIN;
        ST_FIN: begin
          if (!ovalid_q || m_tready_i) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        qtime_q <= in_query;
        cnt_q   <= count_sat;
        idx_q   <= '0;
        found_q <= '0;
        err_q   <= (count_sat == '0);
        for (int c = 0; c < NC; c++) begin
          res_q[c] <= ram_rdata[32+32*c +: 32];
        end
      end
      ST_SCAN_CMP: begin
        if (scan_take) begin
          ent0_q <= ram_rdata;
          for (int c = 0; c < NC; c++) begin
            res_q[c] <= ram_rdata[32+32*c +: 32];
          end
        end
        found_q <= found_n;
        idx_q   <= idx_q + AW'(1);
      end
      ST_NX_WAIT: begin
        ent1_q <= ram_rdata;
        err_q  <= (den_s == '0);
        negk_q <= num_s[32] ^ den_s[32];
        mden_q <= den_s[32] ? 32'(-den_s) : den_s[31:0];
        rem_q  <= '0;
        dvd_q  <= {(num_s[32] ? 32'(-num_s) : num_s[31:0]), FRAC_BITS'(0)};
        bit_q  <= BW'(QW - 1);
      end
      ST_ENT_WAIT: begin
        ent0_q <= ram_rdata;
        for (int c = 0; c < NC; c++) begin
          res_q[c] <= ram_rdata[32+32*c +: 32];
        end
      end
      ST_DIV: begin
        rem_q <= qbit ? 32'(trial - {1'b0, mden_q}) : trial[31:0];
        dvd_q <= {dvd_q[QW-2:0], qbit};
        bit_q <= (bit_q == '0) ? BW'(QW - 1) : bit_q - BW'(1);
        for (int c = 0; c < NC; c++) begin
          prod_q[c] <= '0;
          md_q[c]   <= dif[c][32] ? 32'(-dif[c]) : dif[c][31:0];
          neg_q[c]  <= negk_q ^ dif[c][32];
        end
      end
      ST_MUL: begin
        for (int c = 0; c < NC; c++) begin
          prod_q[c] <= (prod_q[c] << 1) + (dvd_q[QW-1] ? PW'(md_q[c]) : '0);
        end
        dvd_q <= {dvd_q[QW-2:0], 1'b0};
        bit_q <= bit_q - BW'(1);
      end
      ST_CALC: begin
        for (int c = 0; c < NC; c++) begin
          res_q[c] <= calc[c];
        end
      end
      ST_FIN: begin
        if (!ovalid_q || m_tready_i) begin
          for (int c = 0; c < NC; c++) begin
            out_q[c] <= res_q[c];
          end
          oerr_q <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = {out_q[3], out_q[2], out_q[1], out_q[0]};
  assign m_tuser_o  = oerr_q;

  // A new result appears only out of the finishing state.
  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == ST_FIN))
    else $error("result valid rose outside the finishing state");

  // A load never produces a result.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_tuser_i == ktsmp_pkg::MODE_LOAD)) |=> (state_q == ST_IDLE))
    else $error("load transaction left the idle state");

  // The scan never runs past the count in use.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN_CMP) |-> (CW'(idx_q) < cnt_q))
    else $error("scan index beyond the key count");

  // The divider only runs on a nonzero span.
  a_div_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (mden_q != '0))
    else $error("division started on a zero span");

endmodule

### hdl/ktsmp_ram.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ktsmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
